### sv/segment_framer_with_ack_and_retry_assert.svh
// assertion macros for the segment framer
`ifndef SEGMENT_FRAMER_WITH_ACK_AND_RETRY_ASSERT_SVH
`define SEGMENT_FRAMER_WITH_ACK_AND_RETRY_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, codes and constants of the segment framer.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 16;
    localparam logic [7:0] TIMEOUT_RST = 8'd46;
    localparam logic [3:0] MAX_TRIES_RST = 4'd3;
    localparam int HDR_LEN = 5;
    localparam int OVERHEAD = 7;

    typedef enum logic [1:0] {
        REQ_SEND = 2'd0,
        REQ_RX   = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_LINK   = 2'd0,
        KIND_APP    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_ACK_OK   = 3'd1,
        ST_ACK_SEQ  = 3'd2,
        ST_BAD_SUM  = 3'd3,
        ST_BAD_LEN  = 3'd4,
        ST_RETRY    = 3'd5,
        ST_GAVE_UP  = 3'd6,
        ST_DATA_OK  = 3'd7
    } status_t;

    typedef enum logic {
        CFG_TIMEOUT   = 1'b0,
        CFG_MAX_TRIES = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] device;
        logic       is_ack;
        logic       run_end;
        status_t    status;
    } emit_t;

    function automatic logic [7:0] next_seq(input logic [7:0] s);
        logic [7:0] r;
        if (s == 8'd0 || s == 8'd255)
        begin
            r = 8'd1;
        end
        else
        begin
            r = s + 8'd1;
        end
        return r;
    endfunction

endpackage

### sv/sfr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_in_if
// Request channel: valid/ready with one request's fields.
// ----------------------------------------------------------------------------
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic [4:0] payload_len;
    logic [7:0] src_port;
    logic [7:0] dest_port;
    logic [7:0] device;

    modport source (
        output valid, req_type, data_byte, first, last, payload_len, src_port,
               dest_port, device,
        input  ready
    );
    modport sink (
        input  valid, req_type, data_byte, first, last, payload_len, src_port,
               dest_port, device,
        output ready
    );
endinterface

### sv/sfr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_out_if
// Result channel: valid/ready with one result's fields.
// ----------------------------------------------------------------------------
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] out_device;
    logic       is_ack;
    logic       run_end;
    logic [2:0] status;

    modport source (
        output valid, out_kind, out_byte, out_device, is_ack, run_end, status,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_byte, out_device, is_ack, run_end, status,
        output ready
    );
endinterface

### sv/sfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 23
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/sfr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_seq
// Sequencer of the framer: one shared 16-bit adder for send sums, receive
// checksum walk and ACK sums; timer and segment state.
// ----------------------------------------------------------------------------
module sfr_seq #(
    parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
    localparam int RX_DEPTH = MAX_PAYLOAD + sfr_pkg::OVERHEAD,
    localparam int AW = $clog2(RX_DEPTH),
    localparam int CW = $clog2(RX_DEPTH + 1),
    localparam int PW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    sfr_in_if.sink          req_ch,
    input  logic            out_free,
    input  logic [7:0]      timeout_ticks,
    input  logic [3:0]      max_tries,
    output sfr_pkg::emit_t  emit,
    output logic            ram_we,
    output logic [AW-1:0]   ram_waddr,
    output logic [7:0]      ram_wdata,
    output logic [AW-1:0]   ram_raddr,
    input  logic [7:0]      ram_rdata
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_HDR   = 10'b0000000010,
        S_DATA  = 10'b0000000100,
        S_PAD   = 10'b0000001000,
        S_SUMHI = 10'b0000010000,
        S_SUMLO = 10'b0000100000,
        S_STAT  = 10'b0001000000,
        S_RXSUM = 10'b0010000000,
        S_RXCHK = 10'b0100000000,
        S_RXPAY = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [7:0]        seq_reg, seq_next;
    logic [7:0]        tick_reg, tick_next;
    logic [3:0]        try_reg, try_next;
    logic              armed_reg, armed_next;
    logic [15:0]       tx_sum_reg, tx_sum_next;
    logic [15:0]       acc_reg, acc_next;
    logic [CW-1:0]     rx_count_reg, rx_count_next;
    logic              rx_ovf_reg, rx_ovf_next;
    logic              tx_open_reg, tx_open_next;
    logic [PW-1:0]     tx_left_reg, tx_left_next;
    logic [7:0]        hdr_reg [sfr_pkg::HDR_LEN];
    logic [7:0]        hdr_next [sfr_pkg::HDR_LEN];
    logic [7:0]        prev_reg, prev_next;
    logic [7:0]        tail_reg, tail_next;
    // per-request working registers
    logic [7:0]        dev_reg, dev_next;
    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        b1_reg, b1_next;
    logic [7:0]        sp_reg, sp_next;
    logic [7:0]        dp_reg, dp_next;
    logic [7:0]        len_reg, len_next;
    logic [PW-1:0]     pad_reg, pad_next;
    logic              has_data_reg, has_data_next;
    logic              close_reg, close_next;
    logic              ack_mode_reg, ack_mode_next;
    sfr_pkg::status_t  status_reg, status_next;

    logic              accept;
    logic              acc_sel;
    logic              add_en;
    logic [7:0]        add_b;
    logic [15:0]       add_sum;
    logic [15:0]       tgt;
    logic [7:0]        hdr_byte;
    logic [CW-1:0]     cnt_eff;
    logic [CW-1:0]     cnt_new;
    logic              ovf_new;
    logic [PW-1:0]     left_eff;
    logic [PW-1:0]     n_after;
    logic              close_now;
    logic [7:0]        tc;
    logic [3:0]        tr;
    logic              sum_ok;
    logic [PW-1:0]     plen_rx;

    assign req_ch.ready = (state_reg == S_IDLE);
    assign accept = req_ch.valid && req_ch.ready;

    // shared adder: either the running send sum or the scratch accumulator
    assign acc_sel = ack_mode_reg || (state_reg == S_RXSUM);
    assign tgt = acc_sel ? acc_reg : tx_sum_reg;
    assign add_sum = tgt + {8'd0, add_b};

    assign sum_ok = (prev_reg == acc_reg[11:4]) && (tail_reg == acc_reg[7:0]);
    assign plen_rx = PW'(rx_count_reg - CW'(sfr_pkg::OVERHEAD));
    assign ram_raddr = cnt_next[AW-1:0];

    always_comb
    begin
        case (cnt_reg)
            CW'(0):  hdr_byte = seq_reg;
            CW'(1):  hdr_byte = b1_reg;
            CW'(2):  hdr_byte = sp_reg;
            CW'(3):  hdr_byte = dp_reg;
            default: hdr_byte = len_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        seq_next      = seq_reg;
        tick_next     = tick_reg;
        try_next      = try_reg;
        armed_next    = armed_reg;
        tx_sum_next   = tx_sum_reg;
        acc_next      = acc_reg;
        rx_count_next = rx_count_reg;
        rx_ovf_next   = rx_ovf_reg;
        tx_open_next  = tx_open_reg;
        tx_left_next  = tx_left_reg;
        hdr_next      = hdr_reg;
        prev_next     = prev_reg;
        tail_next     = tail_reg;
        dev_next      = dev_reg;
        byte_next     = byte_reg;
        b1_next       = b1_reg;
        sp_next       = sp_reg;
        dp_next       = dp_reg;
        len_next      = len_reg;
        pad_next      = pad_reg;
        has_data_next = has_data_reg;
        close_next    = close_reg;
        ack_mode_next = ack_mode_reg;
        status_next   = status_reg;
        add_en        = 1'b0;
        add_b         = 8'd0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = req_ch.data_byte;
        cnt_eff       = '0;
        cnt_new       = '0;
        ovf_new       = 1'b0;
        left_eff      = '0;
        n_after       = '0;
        close_now     = 1'b0;
        tc            = tick_reg;
        tr            = try_reg;
        emit          = '0;
        emit.status   = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dev_next  = req_ch.device;
                    byte_next = req_ch.data_byte;
                    case (req_ch.req_type)
                        sfr_pkg::REQ_SEND:
                        begin
                            ack_mode_next = 1'b0;
                            status_next   = sfr_pkg::ST_NONE;
                            if (req_ch.first && int'(req_ch.payload_len) > MAX_PAYLOAD)
                            begin
                                tx_open_next = 1'b0;
                                status_next  = sfr_pkg::ST_BAD_LEN;
                                state_next   = S_STAT;
                            end
                            else if (!req_ch.first && !tx_open_reg)
                            begin
                                status_next = sfr_pkg::ST_BAD_LEN;
                                state_next  = S_STAT;
                            end
                            else if (req_ch.first && req_ch.payload_len == 5'd0)
                            begin
                                seq_next      = sfr_pkg::next_seq(seq_reg);
                                b1_next       = 8'd0;
                                sp_next       = req_ch.src_port;
                                dp_next       = req_ch.dest_port;
                                len_next      = 8'd0;
                                tx_sum_next   = 16'd0;
                                has_data_next = 1'b0;
                                pad_next      = '0;
                                close_next    = 1'b1;
                                tx_open_next  = 1'b0;
                                tx_left_next  = '0;
                                armed_next    = 1'b1;
                                tick_next     = 8'd0;
                                try_next      = 4'd0;
                                cnt_next      = '0;
                                state_next    = S_HDR;
                            end
                            else
                            begin
                                left_eff  = req_ch.first ? PW'(req_ch.payload_len) : tx_left_reg;
                                n_after   = left_eff - PW'(1);
                                close_now = (n_after == '0) || req_ch.last;
                                has_data_next = 1'b1;
                                close_next    = close_now;
                                pad_next      = req_ch.last ? n_after : '0;
                                tx_open_next  = !close_now;
                                tx_left_next  = close_now ? '0 : n_after;
                                if (req_ch.last && n_after != '0)
                                begin
                                    status_next = sfr_pkg::ST_BAD_LEN;
                                end
                                if (close_now)
                                begin
                                    armed_next = 1'b1;
                                    tick_next  = 8'd0;
                                    try_next   = 4'd0;
                                end
                                cnt_next = '0;
                                if (req_ch.first)
                                begin
                                    seq_next    = sfr_pkg::next_seq(seq_reg);
                                    b1_next     = 8'd0;
                                    sp_next     = req_ch.src_port;
                                    dp_next     = req_ch.dest_port;
                                    len_next    = {3'd0, req_ch.payload_len};
                                    tx_sum_next = 16'd0;
                                    state_next  = S_HDR;
                                end
                                else
                                begin
                                    state_next = S_DATA;
                                end
                            end
                        end
                        sfr_pkg::REQ_RX:
                        begin
                            cnt_eff = req_ch.first ? '0 : rx_count_reg;
                            ovf_new = req_ch.first ? 1'b0 : rx_ovf_reg;
                            cnt_new = cnt_eff;
                            if (cnt_eff < CW'(RX_DEPTH))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_eff[AW-1:0];
                                cnt_new   = cnt_eff + CW'(1);
                                for (int i = 0; i < sfr_pkg::HDR_LEN; i++)
                                begin
                                    if (cnt_eff == CW'(i))
                                    begin
                                        hdr_next[i] = req_ch.data_byte;
                                    end
                                end
                                prev_next = tail_reg;
                                tail_next = req_ch.data_byte;
                            end
                            else
                            begin
                                ovf_new = 1'b1;
                            end
                            rx_count_next = cnt_new;
                            rx_ovf_next   = ovf_new;
                            if (req_ch.last)
                            begin
                                if (ovf_new || cnt_new < CW'(sfr_pkg::OVERHEAD) ||
                                    hdr_reg[4] != 8'(cnt_new - CW'(sfr_pkg::OVERHEAD)))
                                begin
                                    status_next = sfr_pkg::ST_BAD_LEN;
                                    state_next  = S_STAT;
                                end
                                else
                                begin
                                    acc_next   = 16'd0;
                                    cnt_next   = '0;
                                    state_next = S_RXSUM;
                                end
                            end
                        end
                        sfr_pkg::REQ_TICK:
                        begin
                            if (armed_reg)
                            begin
                                status_next = sfr_pkg::ST_NONE;
                                tc = tick_reg + 8'd1;
                                if (tc == timeout_ticks && tr < max_tries)
                                begin
                                    status_next = sfr_pkg::ST_RETRY;
                                    tc = 8'd0;
                                    tr = tr + 4'd1;
                                end
                                if (tr == max_tries)
                                begin
                                    status_next = sfr_pkg::ST_GAVE_UP;
                                    armed_next  = 1'b0;
                                    tr = 4'd0;
                                    tc = 8'd0;
                                end
                                tick_next = tc;
                                try_next  = tr;
                                if (tc == 8'd0 && (tr != try_reg || !armed_next))
                                begin
                                    state_next = S_STAT;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_HDR:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = sfr_pkg::KIND_LINK;
                    emit.data   = hdr_byte;
                    emit.device = dev_reg;
                    emit.is_ack = ack_mode_reg;
                    add_en = 1'b1;
                    add_b  = hdr_byte;
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(sfr_pkg::HDR_LEN - 1))
                    begin
                        cnt_next = '0;
                        if (has_data_reg)
                        begin
                            state_next = S_DATA;
                        end
                        else if (pad_reg != '0)
                        begin
                            state_next = S_PAD;
                        end
                        else
                        begin
                            state_next = S_SUMHI;
                        end
                    end
                end
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    emit.valid   = 1'b1;
                    emit.kind    = sfr_pkg::KIND_LINK;
                    emit.data    = byte_reg;
                    emit.device  = dev_reg;
                    emit.is_ack  = ack_mode_reg;
                    emit.run_end = !close_reg;
                    add_en = 1'b1;
                    add_b  = byte_reg;
                    cnt_next = '0;
                    if (!close_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (pad_reg != '0)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_SUMHI;
                    end
                end
            end
            S_PAD:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = sfr_pkg::KIND_LINK;
                    emit.device = dev_reg;
                    emit.is_ack = ack_mode_reg;
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(pad_reg) - CW'(1))
                    begin
                        state_next = S_SUMHI;
                    end
                end
            end
            S_SUMHI:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = sfr_pkg::KIND_LINK;
                    emit.data   = tgt[11:4];
                    emit.device = dev_reg;
                    emit.is_ack = ack_mode_reg;
                    state_next  = S_SUMLO;
                end
            end
            S_SUMLO:
            begin
                if (out_free)
                begin
                    emit.valid   = 1'b1;
                    emit.kind    = sfr_pkg::KIND_LINK;
                    emit.data    = tgt[7:0];
                    emit.device  = dev_reg;
                    emit.is_ack  = ack_mode_reg;
                    emit.run_end = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    emit.valid   = 1'b1;
                    emit.kind    = sfr_pkg::KIND_STATUS;
                    emit.run_end = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RXSUM:
            begin
                // read data is the entry at cnt_reg, prefetched by addressing the RAM with cnt_next
                add_en   = 1'b1;
                add_b    = ram_rdata;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == rx_count_reg - CW'(3))
                begin
                    cnt_next   = CW'(sfr_pkg::HDR_LEN);
                    state_next = S_RXCHK;
                end
            end
            S_RXCHK:
            begin
                cnt_next = CW'(sfr_pkg::HDR_LEN);
                if (hdr_reg[1] != 8'd0)
                begin
                    if (hdr_reg[0] != seq_reg)
                    begin
                        status_next = sfr_pkg::ST_ACK_SEQ;
                    end
                    else if (!sum_ok)
                    begin
                        status_next = sfr_pkg::ST_BAD_SUM;
                    end
                    else
                    begin
                        status_next = sfr_pkg::ST_ACK_OK;
                        armed_next  = 1'b0;
                    end
                    state_next = S_STAT;
                end
                else if (!sum_ok)
                begin
                    status_next = sfr_pkg::ST_BAD_SUM;
                    state_next  = S_STAT;
                end
                else
                begin
                    status_next   = sfr_pkg::ST_DATA_OK;
                    seq_next      = sfr_pkg::next_seq(seq_reg);
                    ack_mode_next = 1'b1;
                    acc_next      = 16'd0;
                    b1_next       = hdr_reg[0];
                    sp_next       = hdr_reg[3];
                    dp_next       = hdr_reg[2];
                    len_next      = hdr_reg[4];
                    pad_next      = plen_rx;
                    has_data_next = 1'b0;
                    close_next    = 1'b1;
                    if (plen_rx != '0)
                    begin
                        state_next = S_RXPAY;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = S_HDR;
                    end
                end
            end
            S_RXPAY:
            begin
                if (out_free)
                begin
                    emit.valid = 1'b1;
                    emit.kind  = sfr_pkg::KIND_APP;
                    emit.data  = ram_rdata;
                    cnt_next   = cnt_reg + CW'(1);
                    if (cnt_reg == rx_count_reg - CW'(3))
                    begin
                        cnt_next   = '0;
                        state_next = S_HDR;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (add_en)
        begin
            if (acc_sel)
            begin
                acc_next = add_sum;
            end
            else
            begin
                tx_sum_next = add_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            seq_reg      <= 8'd0;
            tick_reg     <= 8'd0;
            try_reg      <= 4'd0;
            armed_reg    <= 1'b0;
            tx_sum_reg   <= 16'd0;
            rx_count_reg <= '0;
            rx_ovf_reg   <= 1'b0;
            tx_open_reg  <= 1'b0;
            tx_left_reg  <= '0;
            ack_mode_reg <= 1'b0;
            status_reg   <= sfr_pkg::ST_NONE;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            seq_reg      <= seq_next;
            tick_reg     <= tick_next;
            try_reg      <= try_next;
            armed_reg    <= armed_next;
            tx_sum_reg   <= tx_sum_next;
            rx_count_reg <= rx_count_next;
            rx_ovf_reg   <= rx_ovf_next;
            tx_open_reg  <= tx_open_next;
            tx_left_reg  <= tx_left_next;
            ack_mode_reg <= ack_mode_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        hdr_reg      <= hdr_next;
        prev_reg     <= prev_next;
        tail_reg     <= tail_next;
        dev_reg      <= dev_next;
        byte_reg     <= byte_next;
        b1_reg       <= b1_next;
        sp_reg       <= sp_next;
        dp_reg       <= dp_next;
        len_reg      <= len_next;
        pad_reg      <= pad_next;
        has_data_reg <= has_data_next;
        close_reg    <= close_next;
    end

endmodule

### sv/segment_framer_with_ack_and_retry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_framer_with_ack_and_retry
// Transport segment engine: send framing, receive check, ACK reply, retry timer.
// ----------------------------------------------------------------------------
// One request is worked on at a time; ready is high only between requests.
// Requests that give no result (a non-final receive byte, a quiet tick, type 3)
// leave ready high. Every other request puts out one result per cycle while
// the result channel takes them: a send byte gives up to 5 + 1 + pad + 2
// results. The final byte of a received segment of n bytes first walks the
// receive buffer through its single read port with one shared 16-bit adder
// over its first n - 2 bytes and checks it; a good data segment then emits its
// payload and ACK segment at one byte per cycle while the result channel takes
// them. A result waiting in the output register does not block the next request.
module segment_framer_with_ack_and_retry #(
    parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sfr_in_if.sink     req_ch,
    sfr_out_if.source  res_ch,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int RX_DEPTH = MAX_PAYLOAD + sfr_pkg::OVERHEAD;
    localparam int AW = $clog2(RX_DEPTH);

    logic [7:0]     timeout_reg;
    logic [3:0]     max_tries_reg;
    logic           out_valid_reg;
    sfr_pkg::emit_t out_reg;
    sfr_pkg::emit_t emit;
    logic           out_free;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= sfr_pkg::TIMEOUT_RST;
            max_tries_reg <= sfr_pkg::MAX_TRIES_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sfr_pkg::CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            else
            begin
                max_tries_reg <= cfg_data[3:0];
            end
        end
    end

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfr_seq #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_ch        (req_ch),
        .out_free      (out_free),
        .timeout_ticks (timeout_reg),
        .max_tries     (max_tries_reg),
        .emit          (emit),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    // output register
    assign out_free = !out_valid_reg || res_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_reg <= emit;
        end
    end

    assign res_ch.valid      = out_valid_reg;
    assign res_ch.out_kind   = out_reg.kind;
    assign res_ch.out_byte   = out_reg.data;
    assign res_ch.out_device = out_reg.device;
    assign res_ch.is_ack     = out_reg.is_ack;
    assign res_ch.run_end    = out_reg.run_end;
    assign res_ch.status     = out_reg.status;

`include "segment_framer_with_ack_and_retry_assert.svh"

    `SFR_ASSERT_NOW(a_emit_has_room, emit.valid, out_free, "result emitted into a full output register")
    `SFR_ASSERT_NXT(a_ready_after_end, emit.valid && emit.run_end, req_ch.ready, "not ready after last result")
    `SFR_ASSERT_NOW(a_no_emit_idle, req_ch.ready, !emit.valid, "result emitted while waiting for a request")

endmodule

### tb/sv/sfr_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_tb_if
// Testbench view of the framer channels; the block's own interfaces are used.
// ----------------------------------------------------------------------------
// the request and result channels are the sfr_in_if / sfr_out_if interfaces
// shipped with the block; this file only carries the request and result
// records used by the stimulus and expected-result queues
package sfr_tb_pkg;
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic [4:0] payload_len;
        logic [7:0] src_port;
        logic [7:0] dest_port;
        logic [7:0] device;
    } seg_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] device;
        logic       is_ack;
        logic       run_end;
        logic [2:0] status;
    } seg_res_t;
endpackage

### tb/sv/tb_segment_framer_with_ack_and_retry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_framer_with_ack_and_retry
// Self-checking bench for the segment framer: framed sends, received segments
// (good, bad sum, bad length, overflow, acks) and retry ticks are predicted
// in the bench and compared result by result under random flow control.
// ----------------------------------------------------------------------------
module tb_segment_framer_with_ack_and_retry;
    import sfr_pkg::*;
    import sfr_tb_pkg::*;

    localparam int RXD = MAX_PAYLOAD_DEF + OVERHEAD;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [7:0] cfg_data = 8'd0;

    sfr_in_if req_ch();
    sfr_out_if res_ch();

    segment_framer_with_ack_and_retry uut (
        .clk(clk), .rst_n(rst_n), .req_ch(req_ch), .res_ch(res_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // framer state mirror
    logic [7:0] m_timeout, m_seq, m_ticks;
    logic [3:0] m_max_tries, m_tries;
    logic       m_armed, m_ovf, m_open;
    logic [15:0] m_sum;
    logic [7:0] m_rxbuf [RXD];
    int         m_rxcnt, m_left;

    seg_req_t pending_reqs[$];
    seg_res_t expected_results[$];
    seg_res_t item_results[$];
    int errors = 0;
    int n_results = 0;
    bit hold_sender = 0;
    bit long_stall = 0;

    function automatic void push_res(logic [1:0] k, logic [7:0] b, logic [7:0] d, logic a);
        seg_res_t r;
        r.kind = k; r.data = b; r.device = d; r.is_ack = a; r.run_end = 0; r.status = 0;
        item_results.push_back(r);
    endfunction

    function automatic void bump_seq();
        m_seq = (m_seq == 8'd0 || m_seq == 8'd255) ? 8'd1 : m_seq + 8'd1;
    endfunction

    function automatic void frame_byte(logic [7:0] b, logic [7:0] d);
        push_res(KIND_LINK, b, d, 0);
        m_sum = m_sum + b;
    endfunction

    function automatic void frame_close(logic [7:0] d);
        push_res(KIND_LINK, m_sum[11:4], d, 0);
        push_res(KIND_LINK, m_sum[7:0], d, 0);
        m_open = 0; m_left = 0; m_armed = 1; m_ticks = 0; m_tries = 0;
    endfunction

    function automatic status_t check_segment(logic [7:0] d);
        int n, plen;
        logic [15:0] s, a;
        n = m_rxcnt;
        if (m_ovf || n < OVERHEAD || m_rxbuf[4] != n - OVERHEAD) return ST_BAD_LEN;
        plen = n - OVERHEAD;
        s = 0;
        for (int i = 0; i < n - 2; i++) s = s + m_rxbuf[i];
        if (m_rxbuf[1] != 0)
        begin
            if (m_rxbuf[0] != m_seq) return ST_ACK_SEQ;
            if (m_rxbuf[n-2] != s[11:4] || m_rxbuf[n-1] != s[7:0]) return ST_BAD_SUM;
            m_armed = 0;
            return ST_ACK_OK;
        end
        if (m_rxbuf[n-2] != s[11:4] || m_rxbuf[n-1] != s[7:0]) return ST_BAD_SUM;
        for (int i = 0; i < plen; i++) push_res(KIND_APP, m_rxbuf[5+i], 0, 0);
        bump_seq();
        a = m_seq + m_rxbuf[0] + m_rxbuf[3] + m_rxbuf[2] + m_rxbuf[4];
        push_res(KIND_LINK, m_seq, d, 1);
        push_res(KIND_LINK, m_rxbuf[0], d, 1);
        push_res(KIND_LINK, m_rxbuf[3], d, 1);
        push_res(KIND_LINK, m_rxbuf[2], d, 1);
        push_res(KIND_LINK, m_rxbuf[4], d, 1);
        for (int i = 0; i < plen; i++) push_res(KIND_LINK, 0, d, 1);
        push_res(KIND_LINK, a[11:4], d, 1);
        push_res(KIND_LINK, a[7:0], d, 1);
        return ST_DATA_OK;
    endfunction

    function automatic void predict_framer(seg_req_t q);
        status_t st;
        st = ST_NONE;
        item_results.delete();
        case (q.req_type)
            REQ_SEND:
            begin
                if (q.first)
                begin
                    m_open = 0;
                    if (q.payload_len > MAX_PAYLOAD_DEF)
                    begin
                        st = ST_BAD_LEN;
                        push_res(KIND_STATUS, 0, 0, 0);
                    end
                    else
                    begin
                        bump_seq();
                        m_open = 1; m_left = q.payload_len; m_sum = 0;
                        frame_byte(m_seq, q.device);
                        frame_byte(0, q.device);
                        frame_byte(q.src_port, q.device);
                        frame_byte(q.dest_port, q.device);
                        frame_byte({3'b0, q.payload_len}, q.device);
                        if (q.payload_len == 0) frame_close(q.device);
                    end
                end
                if (m_open)
                begin
                    frame_byte(q.data_byte, q.device);
                    m_left--;
                    if (m_left == 0) frame_close(q.device);
                end
                else if (!q.first)
                begin
                    st = ST_BAD_LEN;
                    push_res(KIND_STATUS, 0, 0, 0);
                end
                if (q.last && m_open)
                begin
                    while (m_left > 0)
                    begin
                        frame_byte(0, q.device);
                        m_left--;
                    end
                    frame_close(q.device);
                    st = ST_BAD_LEN;
                end
            end
            REQ_RX:
            begin
                if (q.first)
                begin
                    m_rxcnt = 0; m_ovf = 0;
                end
                if (m_rxcnt < RXD)
                begin
                    m_rxbuf[m_rxcnt] = q.data_byte;
                    m_rxcnt++;
                end
                else m_ovf = 1;
                if (q.last)
                begin
                    st = check_segment(q.device);
                    if (item_results.size() == 0) push_res(KIND_STATUS, 0, 0, 0);
                end
            end
            REQ_TICK:
            begin
                if (m_armed)
                begin
                    m_ticks = m_ticks + 8'd1;
                    if (m_ticks == m_timeout && m_tries < m_max_tries)
                    begin
                        st = ST_RETRY; m_ticks = 0; m_tries++;
                    end
                    if (m_tries == m_max_tries)
                    begin
                        st = ST_GAVE_UP; m_armed = 0; m_tries = 0; m_ticks = 0;
                    end
                    if (st != ST_NONE) push_res(KIND_STATUS, 0, 0, 0);
                end
            end
            default: ;
        endcase
        foreach (item_results[i])
        begin
            item_results[i].status = st;
            item_results[i].run_end = (i == item_results.size() - 1);
            expected_results.push_back(item_results[i]);
        end
    endfunction

    // driver: bursts and gaps; predicts at acceptance
    int gap_left = 0, burst_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= 0; req_ch.data_byte <= 0; req_ch.first <= 0;
            req_ch.last <= 0; req_ch.payload_len <= 0; req_ch.src_port <= 0;
            req_ch.dest_port <= 0; req_ch.device <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_framer(pending_reqs.pop_front());
            end
            if (req_ch.valid && !req_ch.ready)
                ;
            else if (gap_left > 0 || hold_sender || pending_reqs.size() == 0)
            begin
                req_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
            else
            begin
                req_ch.valid <= 1'b1;
                {req_ch.req_type, req_ch.data_byte, req_ch.first, req_ch.last,
                 req_ch.payload_len, req_ch.src_port, req_ch.dest_port,
                 req_ch.device} <= pending_reqs[0];
                if (burst_left > 0) burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
        end
    end

    // receiver stalls: periodic pattern with random jitter, plus one long stretch
    int stall_phase = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 37;
            res_ch.ready <= !long_stall && !(stall_phase < 6 && $urandom_range(0, 1))
                            && ($urandom_range(0, 7) != 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        seg_res_t got, exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.out_kind, res_ch.out_byte, res_ch.out_device, res_ch.is_ack,
                   res_ch.run_end, res_ch.status};
            n_results++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind=%0d byte=%0h", got.kind, got.data);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.kind != exp_r.kind)
                begin
                    $error("out_kind exp %0d got %0d", exp_r.kind, got.kind); errors++;
                end
                if (got.data != exp_r.data)
                begin
                    $error("out_byte exp %0h got %0h", exp_r.data, got.data); errors++;
                end
                if (got.device != exp_r.device)
                begin
                    $error("out_device exp %0h got %0h", exp_r.device, got.device); errors++;
                end
                if (got.is_ack != exp_r.is_ack)
                begin
                    $error("is_ack exp %0d got %0d", exp_r.is_ack, got.is_ack); errors++;
                end
                if (got.run_end != exp_r.run_end)
                begin
                    $error("run_end exp %0d got %0d", exp_r.run_end, got.run_end); errors++;
                end
                if (got.status != exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                end
            end
        end
    end

    function automatic seg_req_t mk(logic [1:0] t, logic [7:0] b, logic f, logic l,
                                     logic [4:0] pl, logic [7:0] sp, logic [7:0] dp,
                                     logic [7:0] dv);
        seg_req_t q;
        q.req_type = t; q.data_byte = b; q.first = f; q.last = l;
        q.payload_len = pl; q.src_port = sp; q.dest_port = dp; q.device = dv;
        return q;
    endfunction

    // queue a send of plen bytes; early_end cuts it short
    task automatic queue_send(int plen, int early_end);
        logic [7:0] dv;
        int nb;
        dv = $urandom;
        nb = (plen == 0) ? 1 : plen;
        if (early_end > 0 && early_end < nb) nb = early_end;
        for (int i = 0; i < nb; i++)
            pending_reqs.push_back(mk(REQ_SEND, $urandom, i == 0, i == nb - 1,
                                      (i == 0) ? plen[4:0] : 5'($urandom),
                                      $urandom, $urandom, dv));
    endtask

    // queue a received segment; flaw: 0 good, 1 bad sum, 2 bad len byte
    task automatic queue_segment(int plen, bit ack, logic [7:0] seqv, int flaw, int extra);
        logic [7:0] seg[$];
        logic [15:0] s;
        logic [7:0] dv;
        seg = {seqv, ack ? 8'($urandom_range(1, 255)) : 8'd0, 8'($urandom), 8'($urandom),
               8'(plen)};
        for (int i = 0; i < plen; i++) seg.push_back($urandom);
        s = 0;
        foreach (seg[i]) s = s + seg[i];
        seg.push_back(s[11:4]);
        seg.push_back(s[7:0] ^ ((flaw == 1) ? 8'h01 : 8'h00));
        if (flaw == 2) seg[4] = seg[4] + 8'd1;
        for (int i = 0; i < extra; i++) seg.push_back($urandom);
        dv = $urandom;
        foreach (seg[i])
            pending_reqs.push_back(mk(REQ_RX, seg[i], i == 0, i == seg.size() - 1,
                                      $urandom, $urandom, $urandom, dv));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || req_ch.valid)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TIMEOUT) m_timeout = v;
        else m_max_tries = v[3:0];
    endtask

    task automatic queue_ticks(int n);
        for (int i = 0; i < n; i++)
            pending_reqs.push_back(mk(REQ_TICK, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom));
    endtask

    initial
    begin
        int r;
        m_timeout = TIMEOUT_RST; m_max_tries = MAX_TRIES_RST;
        m_seq = 0; m_ticks = 0; m_tries = 0; m_armed = 0; m_sum = 0;
        m_rxcnt = 0; m_ovf = 0; m_open = 0; m_left = 0;
        foreach (m_rxbuf[i]) m_rxbuf[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        write_reg(CFG_TIMEOUT, 8'd2);
        write_reg(CFG_MAX_TRIES, 4'd2);
        queue_send(0, 0);
        queue_send(MAX_PAYLOAD_DEF, 0);
        queue_send(3, 2);
        pending_reqs.push_back(mk(REQ_SEND, 8'hff, 1, 0, 5'd31, 8'hff, 8'hff, 8'hff));
        pending_reqs.push_back(mk(REQ_SEND, 8'h00, 0, 1, 5'd17, 8'h00, 8'h00, 8'h00));
        queue_segment(0, 0, 8'h00, 0, 0);
        queue_segment(MAX_PAYLOAD_DEF, 0, 8'hff, 0, 0);
        queue_segment(2, 0, 8'h10, 1, 0);
        queue_segment(2, 0, 8'h10, 2, 0);
        queue_segment(MAX_PAYLOAD_DEF, 0, 8'h10, 0, 3);
        pending_reqs.push_back(mk(REQ_RX, 8'h5a, 1, 1, 0, 0, 0, 0));
        pending_reqs.push_back(mk(REQ_NONE, 8'hff, 1, 1, 5'h1f, 8'hff, 8'hff, 8'hff));
        queue_ticks(6);
        wait_drained();

        // ack wrong sequence, ack bad sum, then correct ack, then timeouts with max tries 1 and 0
        queue_send(1, 0);
        wait_drained();
        queue_segment(0, 1, m_seq + 8'd1, 0, 0);
        queue_segment(0, 1, m_seq, 1, 0);
        queue_segment(0, 1, m_seq, 0, 0);
        queue_ticks(3);
        wait_drained();
        write_reg(CFG_TIMEOUT, 8'd1);
        write_reg(CFG_MAX_TRIES, 4'd1);
        queue_send(2, 0);
        queue_ticks(3);
        wait_drained();
        write_reg(CFG_MAX_TRIES, 4'd0);
        queue_send(1, 0);
        queue_ticks(2);
        wait_drained();

        // long receiver hold-off while sends keep coming
        long_stall = 1;
        for (int i = 0; i < 4; i++) queue_send(MAX_PAYLOAD_DEF, 0);
        repeat (300) @(posedge clk);
        long_stall = 0;
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_TIMEOUT, 8'd255); write_reg(CFG_MAX_TRIES, 4'd15); end
                1: begin write_reg(CFG_TIMEOUT, 8'd3); write_reg(CFG_MAX_TRIES, 4'd3); end
                2: begin write_reg(CFG_TIMEOUT, 8'd0); write_reg(CFG_MAX_TRIES, 4'd1); end
                default: begin write_reg(CFG_TIMEOUT, 8'd2); write_reg(CFG_MAX_TRIES, 4'd4); end
            endcase
            repeat (14)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    queue_send(($urandom_range(0, 5) == 0) ? MAX_PAYLOAD_DEF
                               : $urandom_range(0, 4),
                               ($urandom_range(0, 7) == 0) ? 1 : 0);
                else if (r < 65)
                    queue_segment(($urandom_range(0, 7) == 0) ? MAX_PAYLOAD_DEF
                                  : $urandom_range(0, 3), 0, $urandom,
                                  ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0, 0);
                else if (r < 75)
                    queue_segment(0, 1, ($urandom_range(0, 2) != 0) ? m_seq : 8'($urandom),
                                  ($urandom_range(0, 5) == 0) ? 1 : 0, 0);
                else if (r < 90)
                    queue_ticks($urandom_range(1, 8));
                else
                    pending_reqs.push_back(mk($urandom, $urandom, $urandom, $urandom,
                                              $urandom, $urandom, $urandom, $urandom));
            end
            // in phase 1, sender pause until everything expected is out
            hold_sender = (ph == 1);
            while (hold_sender && expected_results.size() != 0) @(posedge clk);
            hold_sender = 0;
            wait_drained();
        end

        $display("covered framed sends, good/bad/ack/overflow segments and retry ticks");
        $display("%0d results checked across timeout settings 0..255, tries 0..15",
                 n_results);
        if (errors == 0)
            $display("segment_framer_with_ack_and_retry test passed");
        else
            $display("segment_framer_with_ack_and_retry test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("segment_framer_with_ack_and_retry test failed");
        $finish;
    end
endmodule
